[rtl/cakb_pkg.sv]
// ----------------------------------------------------------------------------
// cakb_pkg: shared types and constants of the clipped alpha-key blit
// Field widths, register indexes, the configuration struct and the dimension cap.
// ----------------------------------------------------------------------------
package cakb_pkg;

	localparam int MAX_DIM = 4096;
	localparam int DIM_W   = 13;
	localparam int POS_W   = 14;
	localparam int COORD_W = 12;
	localparam int ADDR_W  = 24;
	localparam int PIXEL_W = 32;
	localparam int ALPHA_W = 8;
	localparam int CFG_W   = 14;
	localparam int IDX_W   = 3;

	localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1);
	localparam logic [ALPHA_W-1:0] KEY_RESET = 8'hff;

	typedef enum logic [IDX_W-1:0] {
		REG_DST_WIDTH  = 3'd0,
		REG_DST_HEIGHT = 3'd1,
		REG_SRC_WIDTH  = 3'd2,
		REG_SRC_HEIGHT = 3'd3,
		REG_POS_X      = 3'd4,
		REG_POS_Y      = 3'd5,
		REG_KEY_ALPHA  = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic [DIM_W-1:0]   dst_width;
		logic [DIM_W-1:0]   dst_height;
		logic [DIM_W-1:0]   src_width;
		logic [DIM_W-1:0]   src_height;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic [ALPHA_W-1:0] key_alpha;
	} cfg_t;

	function automatic logic [DIM_W-1:0] cap_dim(input logic [DIM_W-1:0] v);
		return (v > DIM_MAX) ? DIM_MAX : v;
	endfunction

endpackage

[rtl/cakb_cfg.sv]
// ----------------------------------------------------------------------------
// cakb_cfg: configuration registers
// Holds the blit setup; dimensions are stored already capped to the maximum.
// ----------------------------------------------------------------------------
module cakb_cfg
	import cakb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dst_width  <= DIM_RESET;
			cfg_q.dst_height <= DIM_RESET;
			cfg_q.src_width  <= DIM_RESET;
			cfg_q.src_height <= DIM_RESET;
			cfg_q.pos_x      <= '0;
			cfg_q.pos_y      <= '0;
			cfg_q.key_alpha  <= KEY_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DST_WIDTH:  cfg_q.dst_width  <= cap_dim(cfg_wdata[DIM_W-1:0]);
				REG_DST_HEIGHT: cfg_q.dst_height <= cap_dim(cfg_wdata[DIM_W-1:0]);
				REG_SRC_WIDTH:  cfg_q.src_width  <= cap_dim(cfg_wdata[DIM_W-1:0]);
				REG_SRC_HEIGHT: cfg_q.src_height <= cap_dim(cfg_wdata[DIM_W-1:0]);
				REG_POS_X:      cfg_q.pos_x      <= cfg_wdata[POS_W-1:0];
				REG_POS_Y:      cfg_q.pos_y      <= cfg_wdata[POS_W-1:0];
				REG_KEY_ALPHA:  cfg_q.key_alpha  <= cfg_wdata[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/cakb_raster.sv]
// ----------------------------------------------------------------------------
// cakb_raster: source raster counters
// Column and row of the next source pixel, wrapping at row and frame end.
// ----------------------------------------------------------------------------
module cakb_raster
	import cakb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  cfg_t               cfg,
	output logic [COORD_W-1:0] column,
	output logic [COORD_W-1:0] row
);

	logic [COORD_W-1:0] column_q;
	logic [COORD_W-1:0] row_q;
	logic               col_wrap;
	logic               row_wrap;

	assign col_wrap = ({1'b0, column_q} + DIM_W'(1) >= cfg.src_width) || (&column_q);
	assign row_wrap = ({1'b0, row_q} + DIM_W'(1) >= cfg.src_height) || (&row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (advance) begin
			if (col_wrap) begin
				column_q <= '0;
				row_q    <= row_wrap ? '0 : row_q + COORD_W'(1);
			end else begin
				column_q <= column_q + COORD_W'(1);
			end
		end
	end

	assign column = column_q;
	assign row    = row_q;

endmodule

[rtl/cakb_place.sv]
// ----------------------------------------------------------------------------
// cakb_place: placement, clipping and key test
// Maps a source coordinate onto the target and forms the target pixel index.
// ----------------------------------------------------------------------------
module cakb_place
	import cakb_pkg::*;
(
	input  cfg_t               cfg,
	input  logic [COORD_W-1:0] column,
	input  logic [COORD_W-1:0] row,
	input  logic [ALPHA_W-1:0] alpha,
	output logic               hit,
	output logic [ADDR_W-1:0]  address
);

	localparam int T_W = POS_W + 1;
	localparam int P_W = COORD_W + DIM_W;

	logic [T_W-1:0] tx;
	logic [T_W-1:0] ty;
	logic           x_in;
	logic           y_in;
	logic [P_W-1:0] prod;
	logic [P_W-1:0] sum;

	// sign-extended position plus unsigned source coordinate
	assign tx = {cfg.pos_x[POS_W-1], cfg.pos_x} + {{(T_W-COORD_W){1'b0}}, column};
	assign ty = {cfg.pos_y[POS_W-1], cfg.pos_y} + {{(T_W-COORD_W){1'b0}}, row};

	assign x_in = !tx[T_W-1] && (tx[POS_W-1:0] < {1'b0, cfg.dst_width});
	assign y_in = !ty[T_W-1] && (ty[POS_W-1:0] < {1'b0, cfg.dst_height});
	assign hit  = x_in && y_in && (alpha != cfg.key_alpha);

	assign prod    = {{DIM_W{1'b0}}, ty[COORD_W-1:0]} * {{COORD_W{1'b0}}, cfg.dst_width};
	assign sum     = prod + {{DIM_W{1'b0}}, tx[COORD_W-1:0]};
	assign address = sum[ADDR_W-1:0];

endmodule

[rtl/clipped_alpha_key_blit.sv]
// ----------------------------------------------------------------------------
// clipped_alpha_key_blit: clipped alpha-key blit of a source image onto a target
// Accepted words enter the input register, written words the output register.
// One source word per cycle unless stalled; the clip test and row-times-width
// multiply sit in one stage between the input register and the output register.
// Reset clears the raster counters and pipeline valids and loads the register
// defaults: widths and heights 1, positions 0, key alpha 255.
// ----------------------------------------------------------------------------
module clipped_alpha_key_blit
	import cakb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PIXEL_W-1:0] source_pixel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ADDR_W-1:0]  write_address,
	output logic [PIXEL_W-1:0] write_pixel
);

	cfg_t               cfg;
	logic [COORD_W-1:0] column;
	logic [COORD_W-1:0] row;
	logic               in_acc;

	logic               valid_s1;
	logic [PIXEL_W-1:0] pixel_s1;
	logic [COORD_W-1:0] column_s1;
	logic [COORD_W-1:0] row_s1;

	logic               valid_s2;
	logic [ADDR_W-1:0]  address_s2;
	logic [PIXEL_W-1:0] pixel_s2;

	logic               hit;
	logic [ADDR_W-1:0]  address;
	logic               out_free;
	logic               s1_move;

	cakb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cakb_raster u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (in_acc),
		.cfg     (cfg),
		.column  (column),
		.row     (row)
	);

	cakb_place u_place (
		.cfg     (cfg),
		.column  (column_s1),
		.row     (row_s1),
		.alpha   (pixel_s1[PIXEL_W-1 -: ALPHA_W]),
		.hit     (hit),
		.address (address)
	);

	// clipped or keyed words leave stage 1 without needing the output register
	assign out_free = !valid_s2 || !out_stall;
	assign s1_move  = valid_s1 && (!hit || out_free);
	assign in_stall = valid_s1 && !s1_move;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_s1  <= source_pixel;
			column_s1 <= column;
			row_s1    <= row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move && hit) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && hit) begin
			address_s2 <= address;
			pixel_s2   <= pixel_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign write_address = address_s2;
	assign write_pixel   = pixel_s2;

endmodule
